### hw/rtl/vcts_pkg.sv
// Package: item types, widths and constants of the VCO coarse-tuning SAR.
package vcts_pkg;

    // Field widths of the items
    localparam int FVCO_W = 24;
    localparam int FREF_W = 20;
    localparam int SWC_W  = 8;
    localparam int TRIAL_W = 3;
    localparam int DIV_W  = 10;

    // Divider datapath: num = 8*fvco + fref, den = 2*fref
    localparam int NUM_W = FVCO_W + 4;
    localparam int DEN_W = FREF_W + 1;
    localparam int DIV_STEPS = NUM_W;
    localparam int CNT_W = $clog2(DIV_STEPS);

    localparam logic [NUM_W-1:0] RATIO_MIN = NUM_W'(4);
    localparam logic [NUM_W-1:0] RATIO_MAX = NUM_W'(1027);
    localparam logic [DIV_W-1:0] DIV_SAT   = DIV_W'(1023);

    typedef enum logic {
        REQ_START   = 1'b0,
        REQ_COMPARE = 1'b1
    } t_req_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_OUT
    } t_state;

    typedef struct packed {
        t_req_kind         req_type;
        logic [FVCO_W-1:0] fvco_khz;
        logic [FREF_W-1:0] fref_khz;
        logic              compo;
    } t_req;

    typedef struct packed {
        logic [SWC_W-1:0]   swc_code;
        logic [TRIAL_W-1:0] trial_bit;
        logic [DIV_W-1:0]   int_divider;
        logic               range_error;
        logic               done_res;
        logic               accepted;
    } t_rsp;

endpackage

### hw/rtl/vcts_stream_if.sv
// Interface: valid/ready channel carrying one item of a given type.
interface vcts_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/vco_coarse_tune_sar_unit.sv
// Top level: PLL VCO coarse-tuning controller with divider calculation and SAR search.
//
// Every accepted item gives exactly one response item, and the unit takes one
// item at a time: i_req.ready is high only while nothing is in flight or held
// on the output. A start item (req_type 0) computes N = round(4*fvco/fref),
// halves rounded up, as floor((8*fvco + fref) / (2*fref)) on a 28-bit
// restoring divider that resolves one quotient bit per cycle, so a start
// passes the accept, the divider steps and the response in that order; the
// unit is ready again the cycle after the response is taken. A zero reference
// skips the divider and reports saturation at once.
// int_divider is N-4 clamped to 0..1023 with range_error set when clamped.
// The start also restarts the search with only the top code bit set. A
// comparator item (req_type 1) is handled in the accept cycle: compo=1
// clears the trial bit, then the next lower bit becomes the trial; after
// bit 0 the search stops and done_res goes high. A comparator item while no
// search runs leaves state alone and answers with accepted=0. Its response
// is valid the cycle after accept and holds until taken. CODE_BITS sets the
// code register; swc_code shows its low 8 bits, trial_bit the low 3 bits of the trial index.
module vco_coarse_tune_sar_unit #(
    parameter int CODE_BITS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    vcts_stream_if.sink          i_req,
    vcts_stream_if.source        o_rsp
);
    import vcts_pkg::*;

    localparam int IDX_W = $clog2(CODE_BITS);
    localparam logic [IDX_W-1:0] TOP_IDX = IDX_W'(CODE_BITS - 1);
    localparam logic [CODE_BITS-1:0] ONE_CODE = CODE_BITS'(1);

    t_state                r_state, n_state;
    logic [CODE_BITS-1:0]  r_code, n_code;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic                  r_busy, n_busy;
    logic [DIV_W-1:0]      r_div, n_div;
    logic                  r_rng, n_rng;
    logic                  r_acc, n_acc;
    logic [DEN_W-1:0]      r_rem, n_rem;
    logic [NUM_W-1:0]      r_quo, n_quo;
    logic [DEN_W-1:0]      r_den, n_den;
    logic [CNT_W-1:0]      r_cnt, n_cnt;

    logic                  w_take;
    logic [DEN_W:0]        w_trial;
    logic [DEN_W+1:0]      w_diff;
    logic                  w_ge;
    logic [CODE_BITS-1:0]  w_kept;
    logic [NUM_W-1:0]      w_final_quo;
    logic [CODE_BITS+SWC_W-1:0]  w_code_ext;
    logic [IDX_W+TRIAL_W-1:0]    w_idx_ext;

    assign w_take = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == ST_IDLE);

    // one restoring-division step: shift in next dividend bit, try subtract
    assign w_trial = {r_rem, r_quo[NUM_W-1]};
    assign w_diff  = {1'b0, w_trial} - {2'b00, r_den};
    assign w_ge    = !w_diff[DEN_W+1];
    assign w_final_quo = {r_quo[NUM_W-2:0], w_ge};

    // comparator decision on current trial bit
    assign w_kept = i_req.data.compo ? (r_code & ~(ONE_CODE << r_idx)) : r_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_code  <= '0;
            r_idx   <= TOP_IDX;
            r_busy  <= 1'b0;
            r_div   <= '0;
            r_rng   <= 1'b0;
            r_acc   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
            r_idx   <= n_idx;
            r_busy  <= n_busy;
            r_div   <= n_div;
            r_rng   <= n_rng;
            r_acc   <= n_acc;
        end
    end

    // divider datapath, no reset needed
    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
        r_cnt <= n_cnt;
    end

    always_comb begin
        n_state = r_state;
        n_code  = r_code;
        n_idx   = r_idx;
        n_busy  = r_busy;
        n_div   = r_div;
        n_rng   = r_rng;
        n_acc   = r_acc;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_den   = r_den;
        n_cnt   = r_cnt;
        case (r_state)
            ST_IDLE: begin
                if (w_take) begin
                    n_acc   = 1'b1;
                    n_state = ST_OUT;
                    if (i_req.data.req_type == REQ_START) begin
                        n_idx  = TOP_IDX;
                        n_code = ONE_CODE << TOP_IDX;
                        n_busy = 1'b1;
                        if (i_req.data.fref_khz == '0) begin
                            // zero reference: infinite ratio
                            n_div = DIV_SAT;
                            n_rng = 1'b1;
                        end else begin
                            n_rem   = '0;
                            n_quo   = {1'b0, i_req.data.fvco_khz, 3'b000}
                                      + {8'd0, i_req.data.fref_khz};
                            n_den   = {i_req.data.fref_khz, 1'b0};
                            n_cnt   = CNT_W'(DIV_STEPS - 1);
                            n_state = ST_DIV;
                        end
                    end else if (!r_busy) begin
                        n_acc = 1'b0;
                    end else if (r_idx == '0) begin
                        n_code = w_kept;
                        n_busy = 1'b0;
                    end else begin
                        n_idx  = r_idx - 1'b1;
                        n_code = w_kept | (ONE_CODE << (r_idx - 1'b1));
                    end
                end
            end
            ST_DIV: begin
                n_rem = w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
                n_quo = w_final_quo;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = ST_OUT;
                    if (w_final_quo < RATIO_MIN) begin
                        n_div = '0;
                        n_rng = 1'b1;
                    end else if (w_final_quo > RATIO_MAX) begin
                        n_div = DIV_SAT;
                        n_rng = 1'b1;
                    end else begin
                        n_div = DIV_W'(w_final_quo - RATIO_MIN);
                        n_rng = 1'b0;
                    end
                end
            end
            ST_OUT: begin
                if (o_rsp.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign w_code_ext = {{SWC_W{1'b0}}, r_code};
    assign w_idx_ext  = {{TRIAL_W{1'b0}}, r_idx};

    assign o_rsp.valid            = (r_state == ST_OUT);
    assign o_rsp.data.swc_code    = w_code_ext[SWC_W-1:0];
    assign o_rsp.data.trial_bit   = w_idx_ext[TRIAL_W-1:0];
    assign o_rsp.data.int_divider = r_div;
    assign o_rsp.data.range_error = r_rng;
    assign o_rsp.data.done_res    = !r_busy && (r_idx == '0);
    assign o_rsp.data.accepted    = r_acc;

    // no new item while a response is pending
    a_ready_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready |-> !o_rsp.valid)
        else $error("ready while response pending");

    // a start with nonzero reference enters the divider
    a_start_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && i_req.data.req_type == REQ_START && i_req.data.fref_khz != '0)
        |=> (r_state == ST_DIV))
        else $error("start did not enter divider");

    // divider only runs under an active search
    a_div_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> r_busy)
        else $error("divider running while not busy");

    // last divider step hands over to the response
    a_div_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && r_cnt == '0) |=> (r_state == ST_OUT))
        else $error("divider did not finish");

    // a comparator item while idle leaves the search untouched
    a_idle_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && i_req.data.req_type == REQ_COMPARE && !r_busy)
        |=> (!r_acc && $stable(r_code) && $stable(r_idx)))
        else $error("idle comparator changed state");

endmodule
